// ===== hdl/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Field widths.
  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned HUE_W         = 15;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned CH_MAX        = 255;

  // Hue geometry: one sector spans 60 degrees, a full turn 360 degrees.
  localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int unsigned FULL_TURN   = 360 << HUE_FRAC_BITS;
  localparam int unsigned SPAN_W      = $clog2(SECTOR_SPAN + 1);

  // Channel divide: value = round(bri * (DEN - sat * w) / DEN).
  localparam int unsigned DEN       = CH_MAX * SECTOR_SPAN;
  localparam int unsigned HALF_DEN  = DEN / 2;
  localparam int unsigned DIFF_W    = CH_W + SPAN_W;
  localparam int unsigned NUM_W     = CH_W + DIFF_W;

  // DEN = 255 * 15 * 2^(HUE_FRAC_BITS + 2): shift off the power of two, then
  // divide by the odd part with a reciprocal multiply and one correction.
  localparam int unsigned DEN_SHIFT   = HUE_FRAC_BITS + 2;
  localparam int unsigned DEN_ODD     = DEN >> DEN_SHIFT;
  localparam int unsigned ODD_W       = $clog2(DEN_ODD + 1);
  localparam int unsigned X_W         = NUM_W - DEN_SHIFT;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam longint unsigned RECIP_K = (64'd1 << RECIP_SHIFT) / DEN_ODD;
  localparam int unsigned K_W         = $clog2(RECIP_K + 1);
  localparam int unsigned PROD_W      = X_W + K_W;
  localparam int unsigned QM_W        = CH_W + ODD_W;

  // Pipeline stage positions.
  localparam int unsigned NUM_ST     = 7;
  localparam int unsigned ST_WRAP    = 0;
  localparam int unsigned ST_SPLIT   = 1;
  localparam int unsigned ST_MUL     = 2;
  localparam int unsigned ST_NUM     = 3;
  localparam int unsigned ST_RECIP   = 4;
  localparam int unsigned ST_EST     = 5;
  localparam int unsigned ST_OUT     = 6;
  localparam int unsigned LANE_DEPTH = ST_EST - ST_MUL + 1;

  typedef logic [CH_W-1:0] chan_t;

  // Hue sector, named by the color edge it runs along.
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  // Per-stage load enables and valid bits.
  typedef struct packed {
    logic [NUM_ST-1:0] adv;
    logic [NUM_ST-1:0] vld;
  } flow_t;

endpackage

`default_nettype wire

// ===== hdl/h2r_flow.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_flow (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  output h2r_pkg::flow_t  flow_o,
  output logic            in_stall_o
);
  import h2r_pkg::*;

  logic [NUM_ST-1:0] vld_q;
  logic [NUM_ST-1:0] vld_d;
  logic [NUM_ST:0]   ready;

  // A stage can load when it is empty or its content moves on this cycle.
  always_comb begin
    ready[NUM_ST] = !out_stall_i;
    for (int k = NUM_ST - 1; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k + 1];
    end
  end

  // Valid bits follow the data; a loading stage takes its upstream valid.
  always_comb begin
    vld_d = (ready[NUM_ST-1:0] & {vld_q[NUM_ST-2:0], in_valid_i})
          | (~ready[NUM_ST-1:0] & vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    flow_o.adv = ready[NUM_ST-1:0];
    flow_o.vld = vld_q;
    in_stall_o = !ready[0];
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_hue_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_hue_split (
  input  logic                         clk_i,
  input  h2r_pkg::flow_t               flow_i,
  input  logic [h2r_pkg::HUE_W-1:0]    hue_i,
  input  logic [h2r_pkg::CH_W-1:0]     saturation_i,
  input  logic [h2r_pkg::CH_W-1:0]     brightness_i,
  output h2r_pkg::sector_e             sector_o,
  output logic [h2r_pkg::SPAN_W-1:0]   offset_o,
  output logic [h2r_pkg::CH_W-1:0]     sat_o,
  output logic [h2r_pkg::CH_W-1:0]     bri_o
);
  import h2r_pkg::*;

  logic [HUE_W-1:0]  hm_d;
  logic [HUE_W-1:0]  hm_q;
  logic [CH_W-1:0]   sat0_q;
  logic [CH_W-1:0]   bri0_q;
  sector_e           sec_d;
  sector_e           sec_q;
  logic [HUE_W-1:0]  base;
  logic [SPAN_W-1:0] offset_d;
  logic [SPAN_W-1:0] offset_q;
  logic [CH_W-1:0]   sat1_q;
  logic [CH_W-1:0]   bri1_q;

  // Wrap hues at or above a full turn; the input range needs one subtraction.
  always_comb begin
    if (hue_i >= HUE_W'(FULL_TURN)) begin
      hm_d = hue_i - HUE_W'(FULL_TURN);
    end else begin
      hm_d = hue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_WRAP]) begin
      hm_q   <= hm_d;
      sat0_q <= saturation_i;
      bri0_q <= brightness_i;
    end
  end

  // Find the sector by comparing against the sector boundaries.
  always_comb begin
    priority if (hm_q >= HUE_W'(5 * SECTOR_SPAN)) begin
      sec_d = SEC_M_TO_R;
      base  = HUE_W'(5 * SECTOR_SPAN);
    end else if (hm_q >= HUE_W'(4 * SECTOR_SPAN)) begin
      sec_d = SEC_B_TO_M;
      base  = HUE_W'(4 * SECTOR_SPAN);
    end else if (hm_q >= HUE_W'(3 * SECTOR_SPAN)) begin
      sec_d = SEC_C_TO_B;
      base  = HUE_W'(3 * SECTOR_SPAN);
    end else if (hm_q >= HUE_W'(2 * SECTOR_SPAN)) begin
      sec_d = SEC_G_TO_C;
      base  = HUE_W'(2 * SECTOR_SPAN);
    end else if (hm_q >= HUE_W'(SECTOR_SPAN)) begin
      sec_d = SEC_Y_TO_G;
      base  = HUE_W'(SECTOR_SPAN);
    end else begin
      sec_d = SEC_R_TO_Y;
      base  = '0;
    end
    offset_d = SPAN_W'(hm_q - base);
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_SPLIT]) begin
      sec_q    <= sec_d;
      offset_q <= offset_d;
      sat1_q   <= sat0_q;
      bri1_q   <= bri0_q;
    end
  end

  assign sector_o = sec_q;
  assign offset_o = offset_q;
  assign sat_o    = sat1_q;
  assign bri_o    = bri1_q;

endmodule

`default_nettype wire

// ===== hdl/h2r_chan_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_chan_div (
  input  logic                        clk_i,
  input  h2r_pkg::flow_t              flow_i,
  input  logic [h2r_pkg::SPAN_W-1:0]  weight_i,
  input  logic [h2r_pkg::CH_W-1:0]    sat_i,
  input  logic [h2r_pkg::CH_W-1:0]    bri_i,
  output h2r_pkg::chan_t              value_o
);
  import h2r_pkg::*;

  logic [DIFF_W-1:0] sw_d;
  logic [DIFF_W-1:0] sw_q;
  logic [CH_W-1:0]   bri2_q;
  logic [DIFF_W-1:0] diff;
  logic [NUM_W-1:0]  num_d;
  logic [NUM_W-1:0]  num_q;
  logic [X_W-1:0]    x_d;
  logic [X_W-1:0]    x4_q;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod_q;
  logic [CH_W-1:0]   qe_d;
  logic [CH_W-1:0]   qe_q;
  logic [QM_W-1:0]   qm_d;
  logic [QM_W-1:0]   qm_q;
  logic [X_W-1:0]    x5_q;
  logic [X_W-1:0]    rem;

  // Saturation times the sector weight.
  assign sw_d = sat_i * weight_i;

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_MUL]) begin
      sw_q   <= sw_d;
      bri2_q <= bri_i;
    end
  end

  // Numerator with the rounding half already added.
  assign diff  = DIFF_W'(DEN) - sw_q;
  assign num_d = bri2_q * diff + NUM_W'(HALF_DEN);

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_NUM]) begin
      num_q <= num_d;
    end
  end

  // Drop the power-of-two factor of the divisor, then multiply by the
  // reciprocal of its odd part.
  assign x_d    = num_q[NUM_W-1:DEN_SHIFT];
  assign prod_d = x_d * K_W'(RECIP_K);

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_RECIP]) begin
      prod_q <= prod_d;
      x4_q   <= x_d;
    end
  end

  // The quotient estimate is exact or one short; form its product back.
  assign qe_d = prod_q[RECIP_SHIFT +: CH_W];
  assign qm_d = qe_d * ODD_W'(DEN_ODD);

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_EST]) begin
      qe_q <= qe_d;
      qm_q <= qm_d;
      x5_q <= x4_q;
    end
  end

  // Correct the estimate when the remainder reaches the divisor.
  assign rem = x5_q - X_W'(qm_q);

  always_comb begin
    if (rem >= X_W'(DEN_ODD)) begin
      value_o = qe_q + CH_W'(1);
    end else begin
      value_o = qe_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/h2r_order.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_order (
  input  logic                      clk_i,
  input  h2r_pkg::flow_t            flow_i,
  input  h2r_pkg::sector_e          sector_i,
  input  logic [h2r_pkg::CH_W-1:0]  bri_i,
  input  h2r_pkg::chan_t            p_i,
  input  h2r_pkg::chan_t            q_i,
  input  h2r_pkg::chan_t            t_i,
  output h2r_pkg::chan_t            red_o,
  output h2r_pkg::chan_t            green_o,
  output h2r_pkg::chan_t            blue_o
);
  import h2r_pkg::*;

  sector_e   sec_q [LANE_DEPTH];
  chan_t     bri_q [LANE_DEPTH];
  sector_e   sec_last;
  chan_t     v_val;
  chan_t     red_d;
  chan_t     green_d;
  chan_t     blue_d;
  chan_t     red_q;
  chan_t     green_q;
  chan_t     blue_q;

  // Carry the sector and brightness alongside the channel dividers.
  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_MUL]) begin
      sec_q[0] <= sector_i;
      bri_q[0] <= bri_i;
    end
    for (int k = 1; k < LANE_DEPTH; k++) begin
      if (flow_i.adv[ST_MUL + k]) begin
        sec_q[k] <= sec_q[k - 1];
        bri_q[k] <= bri_q[k - 1];
      end
    end
  end

  assign sec_last = sec_q[LANE_DEPTH-1];
  assign v_val    = bri_q[LANE_DEPTH-1];

  // The sector decides which value goes to which channel.
  always_comb begin
    unique case (sec_last)
      SEC_R_TO_Y: begin
        red_d = v_val; green_d = t_i;   blue_d = p_i;
      end
      SEC_Y_TO_G: begin
        red_d = q_i;   green_d = v_val; blue_d = p_i;
      end
      SEC_G_TO_C: begin
        red_d = p_i;   green_d = v_val; blue_d = t_i;
      end
      SEC_C_TO_B: begin
        red_d = p_i;   green_d = q_i;   blue_d = v_val;
      end
      SEC_B_TO_M: begin
        red_d = t_i;   green_d = p_i;   blue_d = v_val;
      end
      default: begin
        red_d = v_val; green_d = p_i;   blue_d = q_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.adv[ST_OUT]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

// ===== hdl/hsv_to_rgb_pixel_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts one hue/saturation/brightness pixel to 8-bit red, green and blue
// with the hexcone scheme, each channel rounded to nearest (halves round up).
// Hue is in degrees with six fraction bits and wraps at 360 degrees. The unit
// takes one pixel every clock cycle while its input is not stalled. The seven
// register stages are: hue wrap, sector split, saturation-weight product,
// numerator multiply-add, reciprocal multiply, quotient estimate, and the
// output register. The q, t and p values each have their own divider lane. A
// stall on the output fills empty stages first; the input stalls only when
// every stage holds a pixel.

module hsv_to_rgb_pixel_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [h2r_pkg::HUE_W-1:0]  hue_i,
  input  logic [h2r_pkg::CH_W-1:0]   saturation_i,
  input  logic [h2r_pkg::CH_W-1:0]   brightness_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [h2r_pkg::CH_W-1:0]   red_o,
  output logic [h2r_pkg::CH_W-1:0]   green_o,
  output logic [h2r_pkg::CH_W-1:0]   blue_o
);
  import h2r_pkg::*;

  flow_t             flow;
  sector_e           sector;
  logic [SPAN_W-1:0] offset;
  logic [SPAN_W-1:0] t_weight;
  logic [CH_W-1:0]   sat;
  logic [CH_W-1:0]   bri;
  chan_t             p_val;
  chan_t             q_val;
  chan_t             t_val;

  // Stage valid bits and load enables.
  h2r_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .flow_o      (flow),
    .in_stall_o  (in_stall_o)
  );

  // Hue wrap and sector split.
  h2r_hue_split u_split (
    .clk_i        (clk_i),
    .flow_i       (flow),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .sector_o     (sector),
    .offset_o     (offset),
    .sat_o        (sat),
    .bri_o        (bri)
  );

  // q weighs by the offset, t by the rest of the sector, p by the full span.
  assign t_weight = SPAN_W'(SECTOR_SPAN) - offset;

  h2r_chan_div u_div_q (
    .clk_i    (clk_i),
    .flow_i   (flow),
    .weight_i (offset),
    .sat_i    (sat),
    .bri_i    (bri),
    .value_o  (q_val)
  );

  h2r_chan_div u_div_t (
    .clk_i    (clk_i),
    .flow_i   (flow),
    .weight_i (t_weight),
    .sat_i    (sat),
    .bri_i    (bri),
    .value_o  (t_val)
  );

  h2r_chan_div u_div_p (
    .clk_i    (clk_i),
    .flow_i   (flow),
    .weight_i (SPAN_W'(SECTOR_SPAN)),
    .sat_i    (sat),
    .bri_i    (bri),
    .value_o  (p_val)
  );

  // Channel ordering and output register.
  h2r_order u_order (
    .clk_i    (clk_i),
    .flow_i   (flow),
    .sector_i (sector),
    .bri_i    (bri),
    .p_i      (p_val),
    .q_i      (q_val),
    .t_i      (t_val),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o)
  );

  assign out_valid_o = flow.vld[ST_OUT];

endmodule

`default_nettype wire

// ===== hdl/h2r_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h2r_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [h2r_pkg::CH_W-1:0]   red_o,
  input  logic [h2r_pkg::CH_W-1:0]   green_o,
  input  logic [h2r_pkg::CH_W-1:0]   blue_o
);
  import h2r_pkg::*;

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its channel values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("output payload changed while stalled");

  // The input side stalls only behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // An input transfer is followed by a result waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##7 out_valid_o)
    else $error("no result seven cycles after an input transfer");

endmodule

bind hsv_to_rgb_pixel_unit h2r_checker u_h2r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import h2r_pkg::*;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    chan_t            sat;
    chan_t            bri;
  } hsv_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned DRAIN_CYCLES   = 12;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [HUE_W-1:0] hue_i;
  chan_t            saturation_i;
  chan_t            brightness_i;
  logic             out_valid_o;
  logic             out_stall_i;
  chan_t            red_o;
  chan_t            green_o;
  chan_t            blue_o;

  // Colors still owed by the unit, oldest first.
  rgb_t rgb_due_q[$];

  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  int unsigned long_hold_cycles;
  bit          send_gaps_on;
  bit          recv_stalls_on;

  hsv_to_rgb_pixel_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Round half up on the exact quotient.
  function automatic longint unsigned rounded_quotient(longint unsigned num,
                                                       longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Hexcone conversion in exact fixed point: split the wrapped hue into a
  // sector and an offset, form p, q and t, then order them by sector.
  function automatic rgb_t hexcone_rgb(hsv_t px);
    longint unsigned span, den, turn_pos, sec_idx, offs, b, s, pv, qv, tv;
    rgb_t c;
    span     = 64'(SECTOR_SPAN);
    den      = CH_MAX * span;
    b        = 64'(px.bri);
    s        = 64'(px.sat);
    turn_pos = 64'(px.hue);
    turn_pos = turn_pos % FULL_TURN;
    sec_idx  = turn_pos / span;
    offs     = turn_pos - sec_idx * span;
    pv = rounded_quotient(b * (CH_MAX - s), CH_MAX);
    qv = rounded_quotient(b * (den - s * offs), den);
    tv = rounded_quotient(b * (den - s * (span - offs)), den);
    case (sector_e'(sec_idx[2:0]))
      SEC_R_TO_Y: begin
        c.red = chan_t'(b);  c.green = chan_t'(tv); c.blue = chan_t'(pv);
      end
      SEC_Y_TO_G: begin
        c.red = chan_t'(qv); c.green = chan_t'(b);  c.blue = chan_t'(pv);
      end
      SEC_G_TO_C: begin
        c.red = chan_t'(pv); c.green = chan_t'(b);  c.blue = chan_t'(tv);
      end
      SEC_C_TO_B: begin
        c.red = chan_t'(pv); c.green = chan_t'(qv); c.blue = chan_t'(b);
      end
      SEC_B_TO_M: begin
        c.red = chan_t'(tv); c.green = chan_t'(pv); c.blue = chan_t'(b);
      end
      default: begin
        c.red = chan_t'(b);  c.green = chan_t'(pv); c.blue = chan_t'(qv);
      end
    endcase
    return c;
  endfunction

  // Channel values lean toward the extremes, where grey and black live.
  function automatic chan_t rand_channel();
    case ($urandom_range(0, 7))
      0:       return chan_t'(0);
      1:       return chan_t'(CH_MAX);
      default: return chan_t'($urandom_range(0, CH_MAX));
    endcase
  endfunction

  // Mostly legal hues, some near sector edges, some past a full turn.
  function automatic hsv_t random_pixel();
    hsv_t px;
    case ($urandom_range(0, 9))
      0:       px.hue = HUE_W'($urandom_range(FULL_TURN, (1 << HUE_W) - 1));
      1:       px.hue = HUE_W'($urandom_range(1, 5) * SECTOR_SPAN
                               + $urandom_range(0, 2) - 1);
      default: px.hue = HUE_W'($urandom_range(0, FULL_TURN - 1));
    endcase
    px.sat = rand_channel();
    px.bri = rand_channel();
    return px;
  endfunction

  // Offer one pixel, wait for its transfer, then maybe leave a gap.
  task automatic send_pixel(input logic [HUE_W-1:0] h, input chan_t s, input chan_t b);
    hsv_t px;
    px           = '{hue: h, sat: s, bri: b};
    hue_i        <= h;
    saturation_i <= s;
    brightness_i <= b;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    rgb_due_q.push_back(hexcone_rgb(px));
    n_sent++;
    if (send_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_pixel();
    hsv_t px;
    px = random_pixel();
    send_pixel(px.hue, px.sat, px.bri);
  endtask

  // Stop offering and wait until every owed color has come out.
  task automatic pause_input();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rgb_due_q.size() != 0);
  endtask

  // Corners of every field, each sector, wrap, grey and exact halves.
  task automatic test_directed_corners();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    send_pixel(0, 255, 255);
    send_pixel(0, 0, 0);
    send_pixel(HUE_W'(FULL_TURN - 1), 255, 255);
    send_pixel(HUE_W'(FULL_TURN - 1), 128, 200);
    send_pixel(HUE_W'(SECTOR_SPAN - 1), 255, 255);
    // Mid-sector with full saturation and unit brightness lands on a half.
    for (int k = 0; k < 6; k++) begin
      send_pixel(HUE_W'(k * SECTOR_SPAN + SECTOR_SPAN / 2), 255, 1);
    end
    for (int k = 0; k < 6; k++) send_pixel(HUE_W'(k * SECTOR_SPAN), 200, 180);
    send_pixel(10000, 0, 123);
    send_pixel(HUE_W'(FULL_TURN), 255, 255);
    send_pixel(HUE_W'((1 << HUE_W) - 1), 77, 255);
    send_pixel(16383, 255, 128);
  endtask

  // Random pixels in phases with different idling on each side.
  task automatic test_random_mix(input int unsigned count);
    for (int phase = 0; phase < 5; phase++) begin
      send_gaps_on   = (phase % 2 == 0);
      recv_stalls_on = (phase != 1);
      repeat (count / 5) send_random_pixel();
    end
  endtask

  // Hold the output off long enough that the pipeline fills and the input
  // stalls while pixels keep being offered.
  task automatic test_output_hold();
    send_gaps_on     = 1'b0;
    recv_stalls_on   = 1'b0;
    long_hold_cycles = LONG_HOLD;
    repeat (40) send_random_pixel();
  endtask

  // Let the unit drain completely in the middle of a stream.
  task automatic test_drain_pause();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    repeat (20) send_random_pixel();
    pause_input();
    repeat (20) send_random_pixel();
  endtask

  // Back-to-back transfers with no idling on either side.
  task automatic test_full_rate_stream();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (60) send_random_pixel();
  endtask

  // Output side: random stall bursts, or one long hold when asked.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (long_hold_cycles) @(posedge clk_i);
        out_stall_i      <= 1'b0;
        long_hold_cycles = 0;
      end else if (recv_stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each output transfer with the oldest owed color.
  always @(posedge clk_i) begin : check_result
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rgb_due_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red_o, green_o, blue_o);
        n_errors++;
      end else begin
        want = rgb_due_q.pop_front();
        n_results++;
        if (red_o !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, red_o);
          n_errors++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, green_o);
          n_errors++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, blue_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    n_sent           = 0;
    n_results        = 0;
    n_errors         = 0;
    long_hold_cycles = 0;
    send_gaps_on     = 1'b0;
    recv_stalls_on   = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    hue_i        <= '0;
    saturation_i <= '0;
    brightness_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_mix(450);
    test_output_hold();
    test_drain_pause();
    test_full_rate_stream();

    pause_input();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels and checked %0d colors: all six sectors, hue wrap, grey,",
             n_sent, n_results);
    $display("half-way rounding, random stalls on both sides, a long hold and a drain.");
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/h2r_pkg.sv
hdl/h2r_flow.sv
hdl/h2r_hue_split.sv
hdl/h2r_chan_div.sv
hdl/h2r_order.sv
hdl/hsv_to_rgb_pixel_unit.sv
hdl/h2r_checker.sv
bench/testbench.sv
